FILE: rtl/request_header_deframer_macros.svh
// Assertion macros shared by the request header deframer RTL.
`ifndef REQUEST_HEADER_DEFRAMER_MACROS_SVH
`define REQUEST_HEADER_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

`define RHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("request_header_deframer: same-cycle check failed");

`define RHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("request_header_deframer: next-cycle check failed");

`else

`define RHD_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define RHD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/rhd_pkg.sv
// Shared types and codes for the request header deframer.
`default_nettype none

package rhd_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIR_WORDS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FP_WORDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAPH_WORDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PROP_WORDS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PIPE_WORDS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_WORDS = 3'd6;

	localparam logic [3:0] ST_HDR_BYTE = 4'd0;
	localparam logic [3:0] ST_HDR_OK = 4'd1;
	localparam logic [3:0] ST_PAYLOAD = 4'd2;
	localparam logic [3:0] ST_DONE = 4'd3;
	localparam logic [3:0] ST_BAD_HEADER = 4'd4;
	localparam logic [3:0] ST_BAD_BATCH = 4'd5;
	localparam logic [3:0] ST_BAD_TASK = 4'd6;
	localparam logic [3:0] ST_BAD_LENGTH = 4'd7;
	localparam logic [3:0] ST_STATE = 4'd8;
	localparam logic [3:0] ST_CLEARED = 4'd9;
	localparam logic [3:0] ERR_NONE = 4'd0;

	localparam logic [7:0] TASK_SIMILARITY = 8'd0;
	localparam logic [7:0] TASK_GRAPH = 8'd1;
	localparam logic [7:0] TASK_PROPERTY = 8'd2;
	localparam logic [7:0] TASK_PIPELINE = 8'd3;
	localparam logic [7:0] TASK_RELOAD = 8'd4;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam int HDR_BYTES = 16;

	typedef logic [HDR_BYTES-1:0][7:0] rhd_hdr_t;

	typedef struct packed {
		logic [15:0] max_batch;
		logic [10:0] pair_words;
		logic [10:0] fp_words;
		logic [10:0] graph_words;
		logic [10:0] prop_words;
		logic [10:0] pipe_words;
		logic [10:0] reload_words;
	} rhd_cfg_t;

	typedef struct packed {
		logic ok;
		logic [3:0] err;
	} rhd_chk_t;

endpackage

`default_nettype wire

FILE: rtl/request_header_deframer.sv
// Top level of the request header deframer: framing state, payload pass-through, registers.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, cmd, byte_in             | into block
//  out     | out_valid, out_ready, status ... batch_count | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | into block
//
// Each byte passes an input register and a result register, one byte per cycle sustained while
// out is not stalled. The header check on the sixteenth header byte sits between the two registers.
// Reset clears the framing state and loads the register defaults; the header bytes are not cleared.
// A stall on out holds the result register and backs up through the input register to in_ready.
`default_nettype none

module request_header_deframer #(
	parameter int MAGIC = 77,
	parameter int VERSION = 1,
	parameter int SLOT_BYTES = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              cmd,
	input  wire  [7:0]                       byte_in,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [3:0]                       status,
	output logic                             accepted,
	output logic [7:0]                       payload_byte,
	output logic [11:0]                      payload_offset,
	output logic                             last,
	output logic [7:0]                       task_code,
	output logic [12:0]                      frame_length,
	output logic [31:0]                      trace_tag,
	output logic [31:0]                      batch_count,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [rhd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [rhd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rhd_pkg::*;

	`include "request_header_deframer_macros.svh"

	localparam int LEN_W = $clog2(SLOT_BYTES + 1);

	rhd_cfg_t cfg_q;

	logic valid_s1;
	logic cmd_s1;
	logic [7:0] byte_s1;

	rhd_hdr_t header_store_q;
	logic [4:0] header_count_q;
	logic header_valid_q;
	logic [LEN_W-1:0] expected_length_q;
	logic [LEN_W-1:0] payload_count_q;
	logic [3:0] err_q;

	logic [4:0] header_count_d;
	logic header_valid_d;
	logic [LEN_W-1:0] expected_length_d;
	logic [LEN_W-1:0] payload_count_d;
	logic [3:0] err_d;
	logic store_we;

	logic out_valid_s2;
	logic [3:0] status_s2;
	logic accepted_s2;
	logic [7:0] payload_byte_s2;
	logic [11:0] payload_offset_s2;
	logic last_s2;
	logic [7:0] task_code_s2;
	logic [12:0] frame_length_s2;
	logic [31:0] trace_tag_s2;
	logic [31:0] batch_count_s2;

	logic [3:0] status_d;
	logic accepted_d;
	logic [7:0] payload_byte_d;
	logic [11:0] payload_offset_d;
	logic last_d;
	logic [7:0] task_code_d;
	logic [12:0] frame_length_d;
	logic [31:0] trace_tag_d;
	logic [31:0] batch_count_d;

	logic advance;
	logic fire;
	rhd_hdr_t hdr_view;
	rhd_chk_t chk;
	logic [31:0] hdr_len;
	logic [LEN_W-1:0] pc_inc;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_batch <= 16'd64;
			cfg_q.pair_words <= 11'd64;
			cfg_q.fp_words <= 11'd32;
			cfg_q.graph_words <= 11'd512;
			cfg_q.prop_words <= 11'd16;
			cfg_q.pipe_words <= 11'd512;
			cfg_q.reload_words <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_BATCH: cfg_q.max_batch <= cfg_data;
				CFG_PAIR_WORDS: cfg_q.pair_words <= cfg_data[10:0];
				CFG_FP_WORDS: cfg_q.fp_words <= cfg_data[10:0];
				CFG_GRAPH_WORDS: cfg_q.graph_words <= cfg_data[10:0];
				CFG_PROP_WORDS: cfg_q.prop_words <= cfg_data[10:0];
				CFG_PIPE_WORDS: cfg_q.pipe_words <= cfg_data[10:0];
				CFG_RELOAD_WORDS: cfg_q.reload_words <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			byte_s1 <= byte_in;
		end
	end

	// The sixteenth header byte is checked together with the fifteen already stored.
	always_comb begin
		hdr_view = header_store_q;
		if (header_count_q == 5'd15) begin
			hdr_view[15] = byte_s1;
		end
	end

	assign hdr_len = {hdr_view[7], hdr_view[6], hdr_view[5], hdr_view[4]};
	assign pc_inc = payload_count_q + LEN_W'(1);

	rhd_hdr_check #(
		.MAGIC(MAGIC),
		.VERSION(VERSION),
		.SLOT_BYTES(SLOT_BYTES)
	) u_check (
		.hdr(hdr_view),
		.cfg(cfg_q),
		.chk(chk)
	);

	always_comb begin
		header_count_d = header_count_q;
		header_valid_d = header_valid_q;
		expected_length_d = expected_length_q;
		payload_count_d = payload_count_q;
		err_d = err_q;
		store_we = 1'b0;
		status_d = ST_HDR_BYTE;
		accepted_d = 1'b0;
		payload_byte_d = '0;
		payload_offset_d = '0;
		last_d = 1'b0;
		if (cmd_s1 == CMD_CLEAR) begin
			header_count_d = '0;
			header_valid_d = 1'b0;
			expected_length_d = '0;
			payload_count_d = '0;
			err_d = ERR_NONE;
			status_d = ST_CLEARED;
		end else if (err_q != ERR_NONE) begin
			status_d = err_q;
		end else if (!header_valid_q) begin
			store_we = 1'b1;
			accepted_d = 1'b1;
			header_count_d = header_count_q + 5'd1;
			if (header_count_q == 5'd15) begin
				if (!chk.ok) begin
					err_d = chk.err;
					status_d = chk.err;
				end else begin
					header_valid_d = 1'b1;
					expected_length_d = hdr_len[LEN_W-1:0];
					payload_count_d = '0;
					if (hdr_len == 32'd0) begin
						err_d = ST_STATE;
						status_d = ST_DONE;
					end else begin
						status_d = ST_HDR_OK;
					end
				end
			end
		end else begin
			accepted_d = 1'b1;
			payload_byte_d = byte_s1;
			payload_offset_d = 12'(payload_count_q);
			payload_count_d = pc_inc;
			if (pc_inc >= expected_length_q) begin
				last_d = 1'b1;
				err_d = ST_STATE;
				status_d = ST_DONE;
			end else begin
				status_d = ST_PAYLOAD;
			end
		end
		if (cmd_s1 == CMD_DATA && header_count_d == 5'd16) begin
			task_code_d = hdr_view[2];
			frame_length_d = header_valid_d ? 13'(expected_length_d) : 13'd0;
			trace_tag_d = {hdr_view[11], hdr_view[10], hdr_view[9], hdr_view[8]};
			batch_count_d = {hdr_view[15], hdr_view[14], hdr_view[13], hdr_view[12]};
		end else begin
			task_code_d = '0;
			frame_length_d = '0;
			trace_tag_d = '0;
			batch_count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			header_valid_q <= 1'b0;
			expected_length_q <= '0;
			payload_count_q <= '0;
			err_q <= ERR_NONE;
			out_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				header_count_q <= header_count_d;
				header_valid_q <= header_valid_d;
				expected_length_q <= expected_length_d;
				payload_count_q <= payload_count_d;
				err_q <= err_d;
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			header_store_q[header_count_q[3:0]] <= byte_s1;
		end
		if (fire) begin
			status_s2 <= status_d;
			accepted_s2 <= accepted_d;
			payload_byte_s2 <= payload_byte_d;
			payload_offset_s2 <= payload_offset_d;
			last_s2 <= last_d;
			task_code_s2 <= task_code_d;
			frame_length_s2 <= frame_length_d;
			trace_tag_s2 <= trace_tag_d;
			batch_count_s2 <= batch_count_d;
		end
	end

	assign out_valid = out_valid_s2;
	assign status = status_s2;
	assign accepted = accepted_s2;
	assign payload_byte = payload_byte_s2;
	assign payload_offset = payload_offset_s2;
	assign last = last_s2;
	assign task_code = task_code_s2;
	assign frame_length = frame_length_s2;
	assign trace_tag = trace_tag_s2;
	assign batch_count = batch_count_s2;

	`RHD_ASSERT_IMP(a_hdr_complete, clk, arst_n, header_valid_q, header_count_q == 5'd16)
	`RHD_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, header_count_q <= 5'd16)
	`RHD_ASSERT_IMP(a_payload_bound, clk, arst_n, header_valid_q && err_q == ERR_NONE,
		payload_count_q < expected_length_q)
	`RHD_ASSERT_NXT(a_last_done, clk, arst_n, fire && last_d,
		status == ST_DONE && accepted && err_q == ST_STATE)

endmodule

`default_nettype wire

FILE: rtl/rhd_hdr_check.sv
// Header checker: validates a complete 16-byte header against the configuration.
`default_nettype none

module rhd_hdr_check #(
	parameter int MAGIC = 77,
	parameter int VERSION = 1,
	parameter int SLOT_BYTES = 4096
) (
	input  wire rhd_pkg::rhd_hdr_t hdr,
	input  wire rhd_pkg::rhd_cfg_t cfg,
	output rhd_pkg::rhd_chk_t      chk
);
	import rhd_pkg::*;

	localparam int WORDS_W = 28;
	localparam logic [WORDS_W-1:0] MAX_WORDS = WORDS_W'(SLOT_BYTES / 4);

	logic [7:0] task_id;
	logic [31:0] len;
	logic [31:0] batch;
	logic [16:0] batch_p1;
	logic batch_one;
	logic [WORDS_W-1:0] fp_prod;
	logic [WORDS_W-1:0] prop_prod;
	logic [WORDS_W-1:0] words;
	logic [31:0] words_bytes;

	assign task_id = hdr[2];
	assign len = {hdr[7], hdr[6], hdr[5], hdr[4]};
	assign batch = {hdr[15], hdr[14], hdr[13], hdr[12]};
	assign batch_one = (batch == 32'd1);
	assign batch_p1 = {1'b0, batch[15:0]} + 17'd1;
	assign fp_prod = WORDS_W'(cfg.fp_words * batch_p1);
	assign prop_prod = WORDS_W'(cfg.prop_words * batch[15:0]);
	assign words_bytes = {2'b00, words, 2'b00};

	always_comb begin
		chk.ok = 1'b0;
		chk.err = ERR_NONE;
		words = '0;
		case (task_id)
			TASK_SIMILARITY: begin
				words = batch_one ? WORDS_W'(cfg.pair_words) : fp_prod;
			end
			TASK_GRAPH: words = WORDS_W'(cfg.graph_words);
			TASK_PROPERTY: words = prop_prod;
			TASK_PIPELINE: words = WORDS_W'(cfg.pipe_words);
			TASK_RELOAD: words = WORDS_W'(cfg.reload_words);
			default: words = '0;
		endcase
		if (hdr[0] != 8'(MAGIC) || hdr[1] != 8'(VERSION) || hdr[3] != 8'd0) begin
			chk.err = ST_BAD_HEADER;
		end else if (batch == 32'd0 || batch > {16'd0, cfg.max_batch}) begin
			chk.err = ST_BAD_BATCH;
		end else if ((task_id == TASK_GRAPH || task_id == TASK_PIPELINE ||
				task_id == TASK_RELOAD) && !batch_one) begin
			chk.err = ST_BAD_BATCH;
		end else if (task_id > TASK_RELOAD) begin
			chk.err = ST_BAD_TASK;
		end else if (words > MAX_WORDS || len != words_bytes) begin
			chk.err = ST_BAD_LENGTH;
		end else begin
			chk.ok = 1'b1;
		end
	end

endmodule

`default_nettype wire
